// ===== rtl/mck_pkg.sv =====
`timescale 1ns / 1ps

package mck_pkg;

   localparam int unsigned CHAR_W = 8;
   localparam int unsigned UNIT_W = 10;
   localparam int unsigned DUR_W = 13;
   localparam int unsigned UNITS_W = 3;
   localparam int unsigned LEN_W = 3;
   localparam int unsigned PAT_W = 5;
   localparam int unsigned CNT_W = 4;

   localparam logic [UNIT_W-1:0] UNIT_TIME_RESET = 10'd60;

   localparam logic [UNITS_W-1:0] DOT_UNITS = 3'd1;
   localparam logic [UNITS_W-1:0] DASH_UNITS = 3'd3;
   localparam logic [UNITS_W-1:0] GAP_UNITS = 3'd1;
   localparam logic [UNITS_W-1:0] CHAR_END_UNITS = 3'd3;
   localparam logic [UNITS_W-1:0] SPACE_UNITS = 3'd5;

   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_SPACE,
      KIND_GLYPH
   } kind_type;

   // Elements are left aligned in pat: the first element sits in the top bit, 1 is a dash.
   typedef struct packed {
      kind_type           kind;
      logic [LEN_W-1:0]   len;
      logic [PAT_W-1:0]   pat;
   } glyph_type;

   typedef struct packed {
      logic               key_on;
      logic [UNITS_W-1:0] units;
      logic               last;
   } segment_type;

   function automatic glyph_type decode_char(input logic [CHAR_W-1:0] c);
      glyph_type g;
      g.kind = KIND_GLYPH;
      g.len = 3'd0;
      g.pat = 5'b00000;
      unique case (c)
         8'h20: g.kind = KIND_SPACE;
         8'h41: begin g.len = 3'd2; g.pat = 5'b01000; end
         8'h42: begin g.len = 3'd4; g.pat = 5'b10000; end
         8'h43: begin g.len = 3'd4; g.pat = 5'b10100; end
         8'h44: begin g.len = 3'd3; g.pat = 5'b10000; end
         8'h45: begin g.len = 3'd1; g.pat = 5'b00000; end
         8'h46: begin g.len = 3'd4; g.pat = 5'b00100; end
         8'h47: begin g.len = 3'd3; g.pat = 5'b11000; end
         8'h48: begin g.len = 3'd4; g.pat = 5'b00000; end
         8'h49: begin g.len = 3'd2; g.pat = 5'b00000; end
         8'h4A: begin g.len = 3'd4; g.pat = 5'b01110; end
         8'h4B: begin g.len = 3'd3; g.pat = 5'b10100; end
         8'h4C: begin g.len = 3'd4; g.pat = 5'b01000; end
         8'h4D: begin g.len = 3'd2; g.pat = 5'b11000; end
         8'h4E: begin g.len = 3'd2; g.pat = 5'b10000; end
         8'h4F: begin g.len = 3'd3; g.pat = 5'b11100; end
         8'h50: begin g.len = 3'd4; g.pat = 5'b01100; end
         8'h51: begin g.len = 3'd4; g.pat = 5'b11010; end
         8'h52: begin g.len = 3'd3; g.pat = 5'b01000; end
         8'h53: begin g.len = 3'd3; g.pat = 5'b00000; end
         8'h54: begin g.len = 3'd1; g.pat = 5'b10000; end
         8'h55: begin g.len = 3'd3; g.pat = 5'b00100; end
         8'h56: begin g.len = 3'd4; g.pat = 5'b00010; end
         8'h57: begin g.len = 3'd3; g.pat = 5'b01100; end
         8'h58: begin g.len = 3'd4; g.pat = 5'b10010; end
         8'h59: begin g.len = 3'd4; g.pat = 5'b10110; end
         8'h5A: begin g.len = 3'd4; g.pat = 5'b11000; end
         8'h30: begin g.len = 3'd5; g.pat = 5'b11111; end
         8'h31: begin g.len = 3'd5; g.pat = 5'b01111; end
         8'h32: begin g.len = 3'd5; g.pat = 5'b00111; end
         8'h33: begin g.len = 3'd5; g.pat = 5'b00011; end
         8'h34: begin g.len = 3'd5; g.pat = 5'b00001; end
         8'h35: begin g.len = 3'd5; g.pat = 5'b00000; end
         8'h36: begin g.len = 3'd5; g.pat = 5'b10000; end
         8'h37: begin g.len = 3'd5; g.pat = 5'b11000; end
         8'h38: begin g.len = 3'd5; g.pat = 5'b11100; end
         8'h39: begin g.len = 3'd5; g.pat = 5'b11110; end
         default: g.kind = KIND_NONE;
      endcase
      return g;
   endfunction

endpackage

// ===== rtl/mck_req_if.sv =====
`timescale 1ns / 1ps

interface mck_req_if;
   logic                        valid;
   logic                        ready;
   logic [mck_pkg::CHAR_W-1:0]  char_code;

   modport source (output valid, output char_code, input ready);
   modport sink (input valid, input char_code, output ready);
endinterface

// ===== rtl/mck_rsp_if.sv =====
`timescale 1ns / 1ps

interface mck_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        key_on;
   logic [mck_pkg::DUR_W-1:0]   duration;
   logic                        last;

   modport source (output valid, output key_on, output duration, output last, input ready);
   modport sink (input valid, input key_on, input duration, input last, output ready);
endinterface

// ===== rtl/morse_character_keyer.sv =====
`timescale 1ns / 1ps

// Sends one ASCII character per transfer as Morse keying segments, one segment per cycle
// while the output is not stalled. A capital letter or digit with n elements yields 2n+1
// segments and so occupies the segment sequencer until its last segment leaves it, a space
// yields one segment, and any other code yields nothing and is dropped at decode. The path
// is four register stages deep (decode, sequencer, segment, duration), and the first
// segment of a character passes through them in that order. The unit time register may be
// written only while no character is in flight.

module morse_character_keyer (
   input  logic                        clock,
   input  logic                        reset,
   mck_req_if.sink                     req_chan,
   mck_rsp_if.source                   rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [mck_pkg::UNIT_W-1:0]  csr_wr_data
);

   logic [mck_pkg::UNIT_W-1:0]  unit_time_ff;

   logic                        dec_v_ff;
   mck_pkg::glyph_type          dec_ff;
   mck_pkg::glyph_type          dec_in;
   logic                        dec_ready;

   logic                        seq_in_ready;
   logic                        seq_out_valid;
   mck_pkg::segment_type        seq_out_seg;

   logic                        out_v_ff;
   logic                        key_on_ff;
   logic [mck_pkg::DUR_W-1:0]   duration_ff;
   logic [mck_pkg::DUR_W-1:0]   duration_in;
   logic                        last_ff;
   logic                        out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_time_ff <= mck_pkg::UNIT_TIME_RESET;
      end else if (csr_wr_en) begin
         unit_time_ff <= csr_wr_data;
      end
   end

   assign dec_in = mck_pkg::decode_char(req_chan.char_code);
   assign dec_ready = !dec_v_ff || seq_in_ready;
   assign req_chan.ready = dec_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_v_ff <= 1'b0;
      end else if (dec_ready) begin
         dec_v_ff <= req_chan.valid && (dec_in.kind != mck_pkg::KIND_NONE);
      end
   end

   always_ff @(posedge clock) begin
      if (dec_ready) begin
         dec_ff <= dec_in;
      end
   end

   mck_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_v_ff),
      .in_ready  (seq_in_ready),
      .in_glyph  (dec_ff),
      .out_valid (seq_out_valid),
      .out_ready (out_ready),
      .out_seg   (seq_out_seg)
   );

   assign out_ready = !out_v_ff || rsp_chan.ready;
   assign duration_in = mck_pkg::DUR_W'(seq_out_seg.units) * mck_pkg::DUR_W'(unit_time_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_ready) begin
         out_v_ff <= seq_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && seq_out_valid) begin
         key_on_ff <= seq_out_seg.key_on;
         duration_ff <= duration_in;
         last_ff <= seq_out_seg.last;
      end
   end

   assign rsp_chan.valid = out_v_ff;
   assign rsp_chan.key_on = key_on_ff;
   assign rsp_chan.duration = duration_ff;
   assign rsp_chan.last = last_ff;

endmodule

// ===== rtl/mck_sequencer.sv =====
`timescale 1ns / 1ps

module mck_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  mck_pkg::glyph_type   in_glyph,
   output logic                 out_valid,
   input  logic                 out_ready,
   output mck_pkg::segment_type out_seg
);

   logic                          busy_ff;
   mck_pkg::glyph_type            glyph_ff;
   logic [mck_pkg::CNT_W-1:0]     cnt_ff;
   logic                          seg_v_ff;
   mck_pkg::segment_type          seg_ff;

   mck_pkg::segment_type          seg_in;
   logic [mck_pkg::PAT_W-1:0]     pat_sh;
   logic                          seg_ready;
   logic                          push;
   logic                          done;

   always_comb begin
      pat_sh = glyph_ff.pat << cnt_ff[mck_pkg::CNT_W-1:1];
      priority if (glyph_ff.kind == mck_pkg::KIND_SPACE) begin
         seg_in = '{key_on: 1'b0, units: mck_pkg::SPACE_UNITS, last: 1'b1};
      end else if (cnt_ff == {glyph_ff.len, 1'b0}) begin
         seg_in = '{key_on: 1'b0, units: mck_pkg::CHAR_END_UNITS, last: 1'b1};
      end else if (!cnt_ff[0]) begin
         seg_in = '{key_on: 1'b1,
                    units: pat_sh[mck_pkg::PAT_W-1] ? mck_pkg::DASH_UNITS : mck_pkg::DOT_UNITS,
                    last: 1'b0};
      end else begin
         seg_in = '{key_on: 1'b0, units: mck_pkg::GAP_UNITS, last: 1'b0};
      end
   end

   assign seg_ready = !seg_v_ff || out_ready;
   assign push = busy_ff && seg_ready;
   assign done = push && seg_in.last;
   assign in_ready = !busy_ff || done;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         seg_v_ff <= 1'b0;
      end else begin
         if (in_valid && in_ready) begin
            busy_ff <= 1'b1;
         end else if (done) begin
            busy_ff <= 1'b0;
         end
         if (seg_ready) begin
            seg_v_ff <= push;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         glyph_ff <= in_glyph;
         cnt_ff <= '0;
      end else if (push) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (push) begin
         seg_ff <= seg_in;
      end
   end

   assign out_valid = seg_v_ff;
   assign out_seg = seg_ff;

endmodule

// ===== tb/sv/morse_character_keyer_test.sv =====
`timescale 1ns / 1ps

module morse_character_keyer_test;

   typedef struct {
      logic                       key_on;
      logic [mck_pkg::DUR_W-1:0]  duration;
      logic                       last;
   } keying_segment_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [mck_pkg::UNIT_W-1:0] csr_wr_data;

   mck_req_if req_if ();
   mck_rsp_if rsp_if ();

   morse_character_keyer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   keying_segment_type pending_segments[$];
   logic [mck_pkg::UNIT_W-1:0] unit_ticks;
   int error_count = 0;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic string morse_elements(input logic [mck_pkg::CHAR_W-1:0] c);
      case (c)
         "A": return ".-";
         "B": return "-...";
         "C": return "-.-.";
         "D": return "-..";
         "E": return ".";
         "F": return "..-.";
         "G": return "--.";
         "H": return "....";
         "I": return "..";
         "J": return ".---";
         "K": return "-.-";
         "L": return ".-..";
         "M": return "--";
         "N": return "-.";
         "O": return "---";
         "P": return ".--.";
         "Q": return "--.-";
         "R": return ".-.";
         "S": return "...";
         "T": return "-";
         "U": return "..-";
         "V": return "...-";
         "W": return ".--";
         "X": return "-..-";
         "Y": return "-.--";
         "Z": return "--..";
         "0": return "-----";
         "1": return ".----";
         "2": return "..---";
         "3": return "...--";
         "4": return "....-";
         "5": return ".....";
         "6": return "-....";
         "7": return "--...";
         "8": return "---..";
         "9": return "----.";
         default: return "";
      endcase
   endfunction

   task automatic push_segment(input logic on, input logic [mck_pkg::UNITS_W-1:0] units,
                               input logic fin);
      keying_segment_type seg;
      seg.key_on = on;
      seg.duration = mck_pkg::DUR_W'(units) * mck_pkg::DUR_W'(unit_ticks);
      seg.last = fin;
      pending_segments.push_back(seg);
   endtask

   task automatic predict_keying(input logic [mck_pkg::CHAR_W-1:0] c);
      string elements;
      elements = morse_elements(c);
      if (c == mck_pkg::CHAR_SPACE) begin
         push_segment(1'b0, mck_pkg::SPACE_UNITS, 1'b1);
      end else if (elements.len() != 0) begin
         for (int i = 0; i < elements.len(); i++) begin
            push_segment(1'b1, (elements[i] == "-") ? mck_pkg::DASH_UNITS :
                         mck_pkg::DOT_UNITS, 1'b0);
            push_segment(1'b0, mck_pkg::GAP_UNITS, 1'b0);
         end
         push_segment(1'b0, mck_pkg::CHAR_END_UNITS, 1'b1);
      end
   endtask

   task automatic send_char(input logic [mck_pkg::CHAR_W-1:0] c);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.char_code <= c;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      predict_keying(c);
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_if.valid <= 1'b0;
   endtask

   task automatic drain_results();
      stop_sending();
      while (pending_segments.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_unit_time(input logic [mck_pkg::UNIT_W-1:0] value);
      drain_results();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      unit_ticks = value;
   endtask

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      keying_segment_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_segments.size() == 0) begin
            error_count++;
            $display("%0t: unexpected segment key_on=%0d duration=%0d last=%0d", $time,
                     rsp_if.key_on, rsp_if.duration, rsp_if.last);
         end else begin
            want = pending_segments.pop_front();
            if (rsp_if.key_on !== want.key_on) begin
               error_count++;
               $display("%0t: key_on expected %0d actual %0d", $time, want.key_on,
                        rsp_if.key_on);
            end
            if (rsp_if.duration !== want.duration) begin
               error_count++;
               $display("%0t: duration expected %0d actual %0d", $time, want.duration,
                        rsp_if.duration);
            end
            if (rsp_if.last !== want.last) begin
               error_count++;
               $display("%0t: last expected %0d actual %0d", $time, want.last,
                        rsp_if.last);
            end
         end
      end
   end

   function automatic logic [mck_pkg::CHAR_W-1:0] random_char();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) begin
         return mck_pkg::CHAR_W'("A" + $urandom_range(25));
      end else if (pick < 78) begin
         return mck_pkg::CHAR_W'("0" + $urandom_range(9));
      end else if (pick < 88) begin
         return mck_pkg::CHAR_SPACE;
      end
      return mck_pkg::CHAR_W'($urandom_range(255));
   endfunction

   task automatic test_reset_unit_time();
      send_char("E");
      send_char("T");
      send_char(mck_pkg::CHAR_SPACE);
   endtask

   task automatic test_character_classes();
      logic [mck_pkg::CHAR_W-1:0] codes[$];
      codes = '{8'h00, 8'hFF, 8'h7F, 8'h80, "A", "Z", "0", "9", mck_pkg::CHAR_SPACE, "a",
                "z", "@", "[", "/", ":", 8'h1F, "Q"};
      foreach (codes[i]) send_char(codes[i]);
   endtask

   task automatic test_unit_time_extremes();
      write_unit_time(10'd0);
      send_char("5");
      send_char(mck_pkg::CHAR_SPACE);
      write_unit_time(10'd1023);
      send_char("0");
      send_char(mck_pkg::CHAR_SPACE);
      send_char("H");
      write_unit_time(10'd1);
      send_char("B");
      send_char(mck_pkg::CHAR_SPACE);
   endtask

   task automatic test_sender_pause();
      send_char("S");
      send_char("O");
      stop_sending();
      while (pending_segments.size() != 0) @(posedge clock);
      send_char("S");
      send_char(mck_pkg::CHAR_SPACE);
   endtask

   task automatic test_random_text(input int tx_pct, input int rx_pct,
                                   input logic [mck_pkg::UNIT_W-1:0] ticks);
      write_unit_time(ticks);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      repeat (72) send_char(random_char());
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_if.valid = 1'b0;
      req_if.char_code = '0;
      unit_ticks = mck_pkg::UNIT_TIME_RESET;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      tx_idle_pct = 10;
      rx_idle_pct = 75;
      test_reset_unit_time();
      test_character_classes();
      test_unit_time_extremes();
      test_sender_pause();
      test_random_text(10, 75, mck_pkg::UNIT_W'($urandom_range(1, 1000)));
      test_random_text(75, 10, mck_pkg::UNIT_W'($urandom_range(1023)));
      test_random_text(0, 0, mck_pkg::UNIT_W'($urandom_range(1, 1023)));
      drain_results();

      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
